>>> sv/mal_pkg.sv
`timescale 1ns / 1ps
package mal_pkg;

   // Sample and fixed-point format
   localparam int SAMPLE_BITS   = 13;
   localparam int FRACTION_BITS = 8;
   localparam int SQ_BITS       = 2 * SAMPLE_BITS;
   localparam int FV_BITS       = SQ_BITS + FRACTION_BITS;

   // Register widths
   localparam int WINDOW_BITS = 8;
   localparam int CFG_BITS    = 16;
   localparam int NUM_BITS    = FV_BITS + CFG_BITS;

   // Mobility scale
   localparam int LEVEL_BITS  = 4;
   localparam int LEVEL_STEPS = 15;

   // Axes
   localparam int AXES      = 3;
   localparam int AXIS_BITS = $clog2(AXES);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // Request commands
   localparam logic CMD_SAMPLE  = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   // Register map
   localparam int CSR_INDEX_BITS = 2;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_WINDOW_SAMPLES = CSR_INDEX_BITS'(0);
   localparam csr_index_type CSR_FILTER_LENGTH  = CSR_INDEX_BITS'(1);
   localparam csr_index_type CSR_NOISE_FLOOR    = CSR_INDEX_BITS'(2);
   localparam csr_index_type CSR_LEVEL_RANGE    = CSR_INDEX_BITS'(3);

   // Register reset values
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(10);
   localparam logic [CFG_BITS-1:0]    LENGTH_RESET = CFG_BITS'(3000);
   localparam logic [CFG_BITS-1:0]    FLOOR_RESET  = CFG_BITS'(25);
   localparam logic [CFG_BITS-1:0]    RANGE_RESET  = CFG_BITS'(300);

endpackage

>>> sv/mal_mul.sv
`timescale 1ns / 1ps
// Shift-add multiplier: one multiplier bit per cycle, LSB first.
module mal_mul
   import mal_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [FV_BITS-1:0]  multiplicand,
   input  logic [CFG_BITS-1:0] multiplier,
   output logic [NUM_BITS-1:0] product,
   output logic                done
);

   localparam int ACC_BITS  = NUM_BITS + 1;
   localparam int STEP_BITS = $clog2(CFG_BITS + 1);

   logic [ACC_BITS-1:0]  acc_ff, acc_in;
   logic [FV_BITS-1:0]   mcand_ff;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [FV_BITS:0]     upper_sum;

   // Add the multiplicand into the upper half when the current bit is set, then shift
   always_comb begin
      upper_sum = acc_ff[ACC_BITS-1:CFG_BITS];
      if (acc_ff[0]) begin
         upper_sum = upper_sum + {1'b0, mcand_ff};
      end
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = {{(FV_BITS + 1){1'b0}}, multiplier};
         step_in = STEP_BITS'(CFG_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in  = {upper_sum, acc_ff[CFG_BITS-1:0]} >> 1;
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Hold operands and partial product
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (start) begin
         mcand_ff <= multiplicand;
      end
   end

   assign product = acc_ff[NUM_BITS-1:0];
   assign done    = done_ff;

endmodule

>>> sv/mal_div.sv
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle, MSB first. The top CFG_BITS
// of the dividend must already be below the divisor.
module mal_div
   import mal_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] dividend,
   input  logic [CFG_BITS-1:0] divisor,
   output logic [FV_BITS-1:0]  quotient,
   output logic                done
);

   localparam int STEP_BITS = $clog2(FV_BITS + 1);

   logic [CFG_BITS-1:0]  rem_ff, rem_in;
   logic [FV_BITS-1:0]   quo_ff, quo_in;
   logic [CFG_BITS-1:0]  den_ff;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CFG_BITS:0]    shifted;
   logic [CFG_BITS:0]    diff;
   logic                 fits;

   // Shift one dividend bit into the remainder and try the subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[FV_BITS-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[NUM_BITS-1:FV_BITS];
         quo_in  = dividend[FV_BITS-1:0];
         step_in = STEP_BITS'(FV_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[CFG_BITS-1:0] : shifted[CFG_BITS-1:0];
         quo_in  = {quo_ff[FV_BITS-2:0], fits};
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Hold remainder, quotient shift line and divisor
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

>>> sv/mal_level.sv
`timescale 1ns / 1ps
// Mobility level: clamp against floor and top, else a four-step restoring
// division of (value - floor) * 15 by the range.
module mal_level
   import mal_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [FV_BITS-1:0]    filter_value,
   input  logic [CFG_BITS-1:0]   noise_floor,
   input  logic [CFG_BITS-1:0]   level_range,
   output logic [LEVEL_BITS-1:0] level,
   output logic                  done
);

   localparam int NF_BITS   = CFG_BITS + FRACTION_BITS;
   localparam int TOP_BITS  = NF_BITS + 1;
   localparam int LW        = (FV_BITS > TOP_BITS) ? FV_BITS : TOP_BITS;
   localparam int NW        = NF_BITS + LEVEL_BITS;
   localparam int STEP_BITS = $clog2(LEVEL_BITS);

   typedef enum logic [1:0] {L_IDLE, L_CHECK, L_STEP} state_type;

   state_type             state_ff;
   logic [LEVEL_BITS-1:0] level_ff;
   logic                  done_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [NW-1:0]         rem_ff;
   logic [NW-1:0]         dsh_ff;

   logic [LW-1:0]       fv_w, nf_w, top_w, diff;
   logic [NW-1:0]       scaled, den_w, rem_sub;
   logic [CFG_BITS-1:0] range_eff;
   logic                over, under, fits;

   // Compare against the band and set up the dividend
   always_comb begin
      fv_w      = LW'(filter_value);
      nf_w      = LW'(noise_floor) << FRACTION_BITS;
      top_w     = (LW'(noise_floor) + LW'(level_range)) << FRACTION_BITS;
      over      = fv_w > top_w;
      under     = fv_w < nf_w;
      diff      = fv_w - nf_w;
      scaled    = NW'(diff) * NW'(LEVEL_STEPS);
      range_eff = (level_range == '0) ? CFG_BITS'(1) : level_range;
      den_w     = NW'(range_eff) << (FRACTION_BITS + LEVEL_BITS - 1);
      fits      = rem_ff >= dsh_ff;
      rem_sub   = rem_ff - dsh_ff;
   end

   // Sequence the clamp check and the quotient steps
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         level_ff <= '0;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            L_IDLE: begin
               if (start) begin
                  state_ff <= L_CHECK;
               end
            end
            L_CHECK: begin
               if (over) begin
                  level_ff <= LEVEL_BITS'(LEVEL_STEPS);
                  done_ff  <= 1'b1;
                  state_ff <= L_IDLE;
               end else if (under) begin
                  level_ff <= '0;
                  done_ff  <= 1'b1;
                  state_ff <= L_IDLE;
               end else begin
                  level_ff <= '0;
                  step_ff  <= STEP_BITS'(LEVEL_BITS - 1);
                  state_ff <= L_STEP;
               end
            end
            L_STEP: begin
               level_ff <= {level_ff[LEVEL_BITS-2:0], fits};
               if (step_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= L_IDLE;
               end else begin
                  step_ff <= step_ff - STEP_BITS'(1);
               end
            end
            default: begin
               state_ff <= L_IDLE;
            end
         endcase
      end
   end

   // Hold the partial remainder and the shifted divisor
   always_ff @(posedge clock) begin
      if (state_ff == L_CHECK) begin
         rem_ff <= scaled;
         dsh_ff <= den_w;
      end else if (state_ff == L_STEP) begin
         if (fits) begin
            rem_ff <= rem_sub;
         end
         dsh_ff <= dsh_ff >> 1;
      end
   end

   assign level = level_ff;
   assign done  = done_ff;

endmodule

>>> sv/motion_activity_level_tracker.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_ready  command, accel_x, accel_y, accel_z
// rsp      out  rsp_valid/rsp_ready  mobility_level, peak_deviation,
//                                    filtered_whole, window_started
// csr      in   csr_write            csr_index, csr_wdata (no read-back)
//
// One beat at a time. A restart or reference beat goes from accept to
// rsp_valid through the mobility divider (4 steps). A sample that loads
// or raises the filter first scans the 3 axes and squares the peak; an
// averaging sample adds 16 multiplier and 34 divider steps (FV_BITS).
// Reset is synchronous, restores the default registers and clears tracker state.
// A stalled result sits in the output register; the next beat is accepted.
module motion_activity_level_tracker
   import mal_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_command,
   input  logic [SAMPLE_BITS-1:0]    req_accel_x,
   input  logic [SAMPLE_BITS-1:0]    req_accel_y,
   input  logic [SAMPLE_BITS-1:0]    req_accel_z,
   // response
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [LEVEL_BITS-1:0]     rsp_mobility_level,
   output logic [SAMPLE_BITS-1:0]    rsp_peak_deviation,
   output logic [SQ_BITS-1:0]        rsp_filtered_whole,
   output logic                      rsp_window_started,
   // configuration
   input  logic                      csr_write,
   input  csr_index_type             csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_AXIS, S_SQUARE, S_DECIDE, S_MUL_GO, S_MUL,
      S_DIV_GO, S_DIV, S_LEVEL_GO, S_LEVEL, S_DONE
   } state_type;

   // Configuration
   logic [WINDOW_BITS-1:0] window_samples_ff;
   logic [CFG_BITS-1:0]    filter_length_ff;
   logic [CFG_BITS-1:0]    noise_floor_ff;
   logic [CFG_BITS-1:0]    level_range_ff;

   // Control and results
   state_type             state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0] rsp_level_ff;
   logic [SAMPLE_BITS-1:0] rsp_peak_ff;
   logic [SQ_BITS-1:0]    rsp_whole_ff;
   logic                  rsp_started_ff;
   logic                  load_rsp;

   // Tracker state
   sample_type             axis_min_ff [AXES];
   sample_type             axis_min_in [AXES];
   sample_type             axis_max_ff [AXES];
   sample_type             axis_max_in [AXES];
   sample_type             axis_ref_ff [AXES];
   sample_type             axis_ref_in [AXES];
   logic [WINDOW_BITS-1:0] window_left_ff, window_left_in;
   logic [FV_BITS-1:0]     fv_ff, fv_in;
   logic [CFG_BITS-1:0]    count_ff, count_in;
   logic [SAMPLE_BITS-1:0] peak_ff, peak_in;

   // Working registers
   sample_type          sample_ff [AXES];
   sample_type          sample_in [AXES];
   logic [AXIS_BITS-1:0] axis_ff, axis_in;
   logic                started_ff, started_in;
   logic [FV_BITS-1:0]  sq_ff, sq_in;
   logic [CFG_BITS-1:0] mult_ff, mult_in;
   logic [CFG_BITS-1:0] divisor_ff, divisor_in;
   logic [NUM_BITS-1:0] num_ff, num_in;

   // Axis scan
   sample_type             sel_sample, sel_min, sel_max, sel_ref;
   sample_type             new_min, new_max;
   logic [SAMPLE_BITS:0]   lo_diff, hi_diff;
   logic [SAMPLE_BITS-1:0] axis_peak;
   logic [SQ_BITS-1:0]     square;
   logic [CFG_BITS-1:0]    len_eff;

   // Arithmetic units
   logic                  mul_start, mul_done;
   logic [NUM_BITS-1:0]   mul_product;
   logic                  div_start, div_done;
   logic [FV_BITS-1:0]    div_quotient;
   logic                  level_start, level_done;
   logic [LEVEL_BITS-1:0] level_value;

   assign req_ready   = (state_ff == S_IDLE);
   assign mul_start   = (state_ff == S_MUL_GO);
   assign div_start   = (state_ff == S_DIV_GO);
   assign level_start = (state_ff == S_LEVEL_GO);

   mal_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (fv_ff),
      .multiplier   (mult_ff),
      .product      (mul_product),
      .done         (mul_done)
   );

   mal_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (divisor_ff),
      .quotient (div_quotient),
      .done     (div_done)
   );

   mal_level u_level (
      .clock        (clock),
      .reset        (reset),
      .start        (level_start),
      .filter_value (fv_ff),
      .noise_floor  (noise_floor_ff),
      .level_range  (level_range_ff),
      .level        (level_value),
      .done         (level_done)
   );

   // Widen one axis and take its peak distance from the reference
   always_comb begin
      sel_sample = sample_ff[axis_ff];
      sel_min    = axis_min_ff[axis_ff];
      sel_max    = axis_max_ff[axis_ff];
      sel_ref    = axis_ref_ff[axis_ff];
      new_min    = (sel_sample < sel_min) ? sel_sample : sel_min;
      new_max    = (sel_sample > sel_max) ? sel_sample : sel_max;
      lo_diff    = {sel_ref[SAMPLE_BITS-1], sel_ref} - {new_min[SAMPLE_BITS-1], new_min};
      hi_diff    = {new_max[SAMPLE_BITS-1], new_max} - {sel_ref[SAMPLE_BITS-1], sel_ref};
      axis_peak  = (lo_diff[SAMPLE_BITS-1:0] > hi_diff[SAMPLE_BITS-1:0]) ?
                   lo_diff[SAMPLE_BITS-1:0] : hi_diff[SAMPLE_BITS-1:0];
      square     = peak_ff * peak_ff;
      len_eff    = (filter_length_ff == '0) ? CFG_BITS'(1) : filter_length_ff;
   end

   // Next-state logic for the sequencer and its datapath
   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      load_rsp       = 1'b0;
      axis_min_in    = axis_min_ff;
      axis_max_in    = axis_max_ff;
      axis_ref_in    = axis_ref_ff;
      window_left_in = window_left_ff;
      fv_in          = fv_ff;
      count_in       = count_ff;
      peak_in        = peak_ff;
      sample_in      = sample_ff;
      axis_in        = axis_ff;
      started_in     = started_ff;
      sq_in          = sq_ff;
      mult_in        = mult_ff;
      divisor_in     = divisor_ff;
      num_in         = num_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sample_in[0] = req_accel_x;
               sample_in[1] = req_accel_y;
               sample_in[2] = req_accel_z;
               started_in   = 1'b0;
               if (req_command == CMD_RESTART) begin
                  count_in = '0;
                  state_in = S_LEVEL_GO;
               end else if (window_left_ff == '0) begin
                  // New reference: min, max and reference all take the sample
                  axis_min_in[0] = req_accel_x;
                  axis_min_in[1] = req_accel_y;
                  axis_min_in[2] = req_accel_z;
                  axis_max_in[0] = req_accel_x;
                  axis_max_in[1] = req_accel_y;
                  axis_max_in[2] = req_accel_z;
                  axis_ref_in[0] = req_accel_x;
                  axis_ref_in[1] = req_accel_y;
                  axis_ref_in[2] = req_accel_z;
                  window_left_in = window_samples_ff;
                  peak_in        = '0;
                  started_in     = 1'b1;
                  state_in       = S_LEVEL_GO;
               end else begin
                  window_left_in = window_left_ff - WINDOW_BITS'(1);
                  peak_in        = '0;
                  axis_in        = '0;
                  state_in       = S_AXIS;
               end
            end
         end
         S_AXIS: begin
            axis_min_in[axis_ff] = new_min;
            axis_max_in[axis_ff] = new_max;
            peak_in = (axis_peak > peak_ff) ? axis_peak : peak_ff;
            if (axis_ff == AXIS_BITS'(AXES - 1)) begin
               state_in = S_SQUARE;
            end else begin
               axis_in = axis_ff + AXIS_BITS'(1);
            end
         end
         S_SQUARE: begin
            sq_in    = FV_BITS'(square) << FRACTION_BITS;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (count_ff == '0) begin
               fv_in    = sq_ff;
               count_in = CFG_BITS'(1);
               state_in = S_LEVEL_GO;
            end else if (sq_ff > fv_ff) begin
               fv_in    = sq_ff;
               state_in = S_LEVEL_GO;
            end else if (count_ff < len_eff) begin
               divisor_in = count_ff;
               mult_in    = count_ff - CFG_BITS'(1);
               count_in   = count_ff + CFG_BITS'(1);
               state_in   = S_MUL_GO;
            end else begin
               divisor_in = len_eff;
               mult_in    = len_eff - CFG_BITS'(1);
               state_in   = S_MUL_GO;
            end
         end
         S_MUL_GO: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            if (mul_done) begin
               num_in   = mul_product + NUM_BITS'(sq_ff);
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               fv_in    = div_quotient;
               state_in = S_LEVEL_GO;
            end
         end
         S_LEVEL_GO: begin
            state_in = S_LEVEL;
         end
         S_LEVEL: begin
            if (level_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Load the output register once the previous beat has left
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold sequencer state and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_rsp) begin
            rsp_level_ff   <= level_value;
            rsp_peak_ff    <= peak_ff;
            rsp_whole_ff   <= fv_ff[FV_BITS-1:FRACTION_BITS];
            rsp_started_ff <= started_ff;
         end
      end
   end

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         window_samples_ff <= WINDOW_RESET;
         filter_length_ff  <= LENGTH_RESET;
         noise_floor_ff    <= FLOOR_RESET;
         level_range_ff    <= RANGE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_SAMPLES: window_samples_ff <= csr_wdata[WINDOW_BITS-1:0];
            CSR_FILTER_LENGTH:  filter_length_ff  <= csr_wdata;
            CSR_NOISE_FLOOR:    noise_floor_ff    <= csr_wdata;
            CSR_LEVEL_RANGE:    level_range_ff    <= csr_wdata;
         endcase
      end
   end

   // Hold tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AXES; i++) begin
            axis_min_ff[i] <= '0;
            axis_max_ff[i] <= '0;
            axis_ref_ff[i] <= '0;
         end
         window_left_ff <= '0;
         fv_ff          <= '0;
         count_ff       <= '0;
         peak_ff        <= '0;
      end else begin
         axis_min_ff    <= axis_min_in;
         axis_max_ff    <= axis_max_in;
         axis_ref_ff    <= axis_ref_in;
         window_left_ff <= window_left_in;
         fv_ff          <= fv_in;
         count_ff       <= count_in;
         peak_ff        <= peak_in;
      end
   end

   // Hold working registers
   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      axis_ff    <= axis_in;
      started_ff <= started_in;
      sq_ff      <= sq_in;
      mult_ff    <= mult_in;
      divisor_ff <= divisor_in;
      num_ff     <= num_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mobility_level = rsp_level_ff;
   assign rsp_peak_deviation = rsp_peak_ff;
   assign rsp_filtered_whole = rsp_whole_ff;
   assign rsp_window_started = rsp_started_ff;

endmodule

>>> sv/mal_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the activity tracker
module mal_checker
   import mal_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [LEVEL_BITS-1:0]  rsp_mobility_level,
   input logic [SAMPLE_BITS-1:0] rsp_peak_deviation,
   input logic [SQ_BITS-1:0]     rsp_filtered_whole,
   input logic                   rsp_window_started
);

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mobility_level) &&
      $stable(rsp_peak_deviation) && $stable(rsp_filtered_whole) &&
      $stable(rsp_window_started))
      else $error("stalled result beat changed");

   // A reference beat has no deviation yet
   a_ref_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_window_started |-> rsp_peak_deviation == '0)
      else $error("reference beat with nonzero peak deviation");

   // Drop ready while a beat is in work
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while one is in work");

   // A result never appears right after an accept
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result raised in the cycle after accept");

endmodule

bind motion_activity_level_tracker mal_checker u_mal_checker (.*);
